FILE: hw/rtl/psd_pkg.sv
// Shared types and constants for the Prufer sequence decoder.
// Holds the controller state encoding and the command and status bundles.
// Depends on nothing; the top level, controller and datapath import it.
package psd_pkg;

	// Field widths fixed by the block's interface.
	localparam int SYM_W   = 5;
	localparam int COUNT_W = 6;
	localparam int CFG_W   = 6;

	localparam logic [COUNT_W-1:0] COUNT_SAT    = 6'd63;
	localparam logic [CFG_W-1:0]   N_RESET      = 6'd3;
	localparam logic [CFG_W-1:0]   N_MIN        = 6'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_CHK,
		ST_ERR_OUT,
		ST_EDGE_RD,
		ST_EDGE_OUT,
		ST_FIN_VEC,
		ST_FIN_FIRST,
		ST_FIN_OUT
	} psd_state_t;

	// Which result the output register loads.
	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_ERR,
		OUT_EDGE,
		OUT_FINAL
	} psd_out_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic         load;
		logic         rd_en;
		logic         cnt_step;
		logic         elig_edge;
		logic         elig_fin;
		logic         fin_first;
		logic         edge_commit;
		logic         run_end;
		psd_out_sel_t out_sel;
	} psd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_last;
		logic run_bad;
		logic err;
		logic sym_bad;
		logic pos_last;
		logic out_free;
	} psd_stat_t;

endpackage

FILE: hw/rtl/prufer_sequence_decode.sv
// Prufer sequence decoder, top level. Load takes one code symbol per cycle while idle.
// After the request marked last, the count pass reads and checks each symbol,
// the edge pass makes each edge with one store read and one leaf pick, then
// the final edge is formed from the two labels left; a rejected run reports
// a single error result instead.
// Reset clears all run state and sets the vertex count to 3; the store is not cleared.
module prufer_sequence_decode #(
	parameter int MAX_VERTICES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data,
	input  logic       code_valid,
	output logic       code_stall,
	input  logic [4:0] code_symbol,
	input  logic       is_last,
	output logic       edge_valid,
	input  logic       edge_stall,
	output logic [4:0] edge_low,
	output logic [4:0] edge_high,
	output logic       last_edge,
	output logic       bad_sequence
);

	import psd_pkg::*;

	psd_cmd_t  cmd;
	psd_stat_t stat;
	logic      cfg_we;

	// The vertex count register takes a write in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	psd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	psd_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.code_symbol  (code_symbol),
		.is_last      (is_last),
		.cmd          (cmd),
		.stat         (stat),
		.edge_valid   (edge_valid),
		.edge_stall   (edge_stall),
		.edge_low     (edge_low),
		.edge_high    (edge_high),
		.last_edge    (last_edge),
		.bad_sequence (bad_sequence)
	);

endmodule

FILE: hw/rtl/psd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module psd_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/psd_ctrl.sv
// Controller state machine of the Prufer sequence decoder.
// Sequences the load, count, edge and final phases and the error result through psd_cmd_t.
// Depends on psd_pkg.
module psd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              code_valid,
	output logic              code_stall,
	input  psd_pkg::psd_stat_t stat,
	output psd_pkg::psd_cmd_t  cmd
);

	import psd_pkg::*;

	psd_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = OUT_NONE;
		code_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				code_stall = 1'b0;
				if (code_valid) begin
					cmd.load = 1'b1;
					if (stat.in_last) begin
						state_d = stat.run_bad ? ST_ERR_OUT : ST_CNT_RD;
					end
				end
			end
			ST_CNT_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CNT_CHK;
			end
			ST_CNT_CHK: begin
				cmd.cnt_step = 1'b1;
				if (stat.pos_last) begin
					state_d = (stat.err || stat.sym_bad) ? ST_ERR_OUT : ST_EDGE_RD;
				end else begin
					state_d = ST_CNT_RD;
				end
			end
			ST_ERR_OUT: begin
				if (stat.out_free) begin
					cmd.out_sel = OUT_ERR;
					cmd.run_end = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_EDGE_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.elig_edge = 1'b1;
				state_d       = ST_EDGE_OUT;
			end
			ST_EDGE_OUT: begin
				if (stat.out_free) begin
					cmd.out_sel     = OUT_EDGE;
					cmd.edge_commit = 1'b1;
					state_d         = stat.pos_last ? ST_FIN_VEC : ST_EDGE_RD;
				end
			end
			ST_FIN_VEC: begin
				cmd.elig_fin = 1'b1;
				state_d      = ST_FIN_FIRST;
			end
			ST_FIN_FIRST: begin
				cmd.fin_first = 1'b1;
				state_d       = ST_FIN_OUT;
			end
			ST_FIN_OUT: begin
				if (stat.out_free) begin
					cmd.out_sel = OUT_FINAL;
					cmd.run_end = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A result is only loaded when the output register can take it.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_sel != OUT_NONE) |-> stat.out_free)
		else $error("result loaded while output register busy");

	// A blocked edge result keeps the controller waiting in place.
	a_edge_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDGE_OUT && !stat.out_free) |=> (state_q == ST_EDGE_OUT))
		else $error("edge result dropped while output busy");

endmodule

FILE: hw/rtl/psd_datapath.sv
// Datapath of the Prufer sequence decoder: code store, per-label occurrence
// cells, used mask, leaf search and the output register.
// Depends on psd_pkg and psd_ram.
module psd_datapath #(
	parameter int MAX_VERTICES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_data,
	input  logic [4:0]         code_symbol,
	input  logic               is_last,
	input  psd_pkg::psd_cmd_t  cmd,
	output psd_pkg::psd_stat_t stat,
	output logic               edge_valid,
	input  logic               edge_stall,
	output logic [4:0]         edge_low,
	output logic [4:0]         edge_high,
	output logic               last_edge,
	output logic               bad_sequence
);

	import psd_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int LW = (AW > SYM_W) ? AW : SYM_W;
	localparam int CW = AW;

	logic [CFG_W-1:0]        n_q;
	logic [COUNT_W-1:0]      count_q, count_inc;
	logic                    err_q, err_load, size_bad, sym_bad;
	logic [MAX_VERTICES-1:0] used_q, elig_q, below_n, occ_zero, avail, leaf_hot;
	logic [CW-1:0]           occ_q [MAX_VERTICES];
	logic [AW-1:0]           pos_q;
	logic                    pos_last;
	logic                    ram_we;
	logic [SYM_W-1:0]        rd_data;
	logic [LW-1:0]           sym_ext, leaf, first_q, lo, hi;
	logic                    out_valid_q;
	logic [SYM_W-1:0]        edge_low_q, edge_high_q;
	logic                    last_q, bad_q;

	// Lowest set bit of a label vector, as a label.
	function automatic logic [LW-1:0] first_set(input logic [MAX_VERTICES-1:0] v);
		logic [LW-1:0] idx;
		idx = '0;
		for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
			if (v[j]) begin
				idx = LW'(j);
			end
		end
		return idx;
	endfunction

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= N_RESET;
		end else if (cfg_we) begin
			n_q <= cfg_data;
		end
	end

	// Checks made as a symbol is loaded.
	assign count_inc = (count_q == COUNT_SAT) ? count_q : count_q + 6'd1;
	assign err_load  = err_q | ({1'b0, code_symbol} >= n_q);
	assign size_bad  = (n_q < N_MIN) || (7'(n_q) > 7'(MAX_VERTICES)) ||
		(count_inc != n_q - 6'd2);
	assign ram_we    = cmd.load && (7'(count_q) < 7'(MAX_VERTICES));

	// Code store.
	psd_ram #(
		.WIDTH (SYM_W),
		.DEPTH (MAX_VERTICES)
	) u_code_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (code_symbol),
		.re    (cmd.rd_en),
		.raddr (pos_q),
		.rdata (rd_data)
	);

	// The last code position is n-3, since the code holds n-2 symbols.
	assign sym_ext  = LW'(rd_data);
	assign sym_bad  = ({1'b0, rd_data} >= n_q);
	assign pos_last = (7'(pos_q) == 7'(n_q) - 7'd3);

	// Run counters and error flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= 1'b0;
		end else if (cmd.run_end) begin
			count_q <= '0;
			err_q   <= 1'b0;
		end else if (cmd.load) begin
			count_q <= count_inc;
			err_q   <= err_load | (is_last & size_bad);
		end else if (cmd.cnt_step && sym_bad) begin
			err_q   <= 1'b1;
		end
	end

	// Code position walked by the count and edge passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.run_end) begin
			pos_q <= '0;
		end else if (cmd.cnt_step || cmd.edge_commit) begin
			pos_q <= pos_last ? '0 : pos_q + 1'b1;
		end
	end

	// Per-label occurrence cells: each counts how often its label occurs
	// at the current code position or later.
	for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_cell
		logic hit;
		assign hit         = (sym_ext == LW'(j));
		assign below_n[j]  = (7'(j) < 7'(n_q));
		assign occ_zero[j] = (occ_q[j] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				occ_q[j] <= '0;
			end else if (cmd.run_end) begin
				occ_q[j] <= '0;
			end else if (cmd.cnt_step && hit) begin
				occ_q[j] <= occ_q[j] + 1'b1;
			end else if (cmd.edge_commit && hit) begin
				occ_q[j] <= occ_q[j] - 1'b1;
			end
		end
	end

	assign avail    = ~used_q & below_n;
	assign leaf_hot = elig_q & ~(elig_q - 1'b1);
	assign leaf     = first_set(elig_q);

	// Used label mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.run_end) begin
			used_q <= '0;
		end else if (cmd.edge_commit) begin
			used_q <= used_q | leaf_hot;
		end
	end

	// Candidate vector and first remaining label.
	always_ff @(posedge clk) begin
		if (cmd.elig_edge) begin
			elig_q <= avail & occ_zero;
		end else if (cmd.elig_fin) begin
			elig_q <= avail;
		end else if (cmd.fin_first) begin
			elig_q  <= elig_q & (elig_q - 1'b1);
			first_q <= leaf;
		end
	end

	// Order the edge's two labels.
	assign lo = (sym_ext < leaf) ? sym_ext : leaf;
	assign hi = (sym_ext < leaf) ? leaf : sym_ext;

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_sel != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!edge_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		unique case (cmd.out_sel)
			OUT_ERR: begin
				edge_low_q  <= '0;
				edge_high_q <= '0;
				last_q      <= 1'b1;
				bad_q       <= 1'b1;
			end
			OUT_EDGE: begin
				edge_low_q  <= lo[SYM_W-1:0];
				edge_high_q <= hi[SYM_W-1:0];
				last_q      <= 1'b0;
				bad_q       <= 1'b0;
			end
			OUT_FINAL: begin
				edge_low_q  <= first_q[SYM_W-1:0];
				edge_high_q <= leaf[SYM_W-1:0];
				last_q      <= 1'b1;
				bad_q       <= 1'b0;
			end
			OUT_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign edge_valid   = out_valid_q;
	assign edge_low     = edge_low_q;
	assign edge_high    = edge_high_q;
	assign last_edge    = last_q;
	assign bad_sequence = bad_q;

	// Status to the controller.
	assign stat.in_last  = is_last;
	assign stat.run_bad  = err_load | size_bad;
	assign stat.err      = err_q;
	assign stat.sym_bad  = sym_bad;
	assign stat.pos_last = pos_last;
	assign stat.out_free = !out_valid_q || !edge_stall;

	// Every occurrence counted is consumed by the time the last code edge is made.
	a_occ_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.edge_commit && pos_last) |=> (&occ_zero))
		else $error("occurrence counts not drained after edge pass");

	// A valid code leaves exactly two labels for the final edge.
	a_two_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.elig_fin |-> ($countones(avail) == 2))
		else $error("final edge does not have two free labels");

	// An edge is only committed with a candidate leaf present.
	a_leaf_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.edge_commit |-> (elig_q != '0))
		else $error("no leaf candidate for code position");

	// Count steps consume data read in the previous cycle.
	a_cnt_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_step |-> $past(cmd.rd_en))
		else $error("count step without store read");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the Prufer sequence decoder (prufer_sequence_decode).
// Predicts every edge and error result in SystemVerilog and compares them in order.
// Depends on psd_pkg and the top-level RTL only.
module testbench;
	import psd_pkg::*;

	localparam int MAX_VERTICES   = 32;
	localparam int RANDOM_ITEMS   = 300;
	localparam int SETTLE_CYCLES  = 4 * MAX_VERTICES + 12;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
	typedef enum int {RUN_GOOD, RUN_BAD_SYMBOL, RUN_BAD_COUNT, RUN_NOISE} run_kind_t;

	typedef struct packed {
		logic [SYM_W-1:0] lo;
		logic [SYM_W-1:0] hi;
		logic             last;
		logic             bad;
	} tree_edge_t;

	// Ports of the block; the inputs are at known values from time zero.
	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             code_valid = 1'b0;
	logic             code_stall;
	logic [SYM_W-1:0] code_symbol = '0;
	logic             is_last = 1'b0;
	logic             edge_valid;
	logic             edge_stall = 1'b0;
	logic [SYM_W-1:0] edge_low;
	logic [SYM_W-1:0] edge_high;
	logic             last_edge;
	logic             bad_sequence;

	// Decoder model state.
	logic [SYM_W-1:0]   code_mem [MAX_VERTICES];
	logic [COUNT_W-1:0] sym_count = '0;
	logic               run_bad = 1'b0;
	logic [CFG_W-1:0]   vcount = N_RESET;
	tree_edge_t         expected_edges [$];

	// Stimulus state.
	logic [SYM_W-1:0] pending_code [$];
	stall_mode_t      stall_mode = STALL_NONE;
	bit               gaps_on = 1'b1;
	int               burst_left = 0;
	int               sent_count = 0;
	int               error_count = 0;
	int               idle_cycles = 0;
	logic [7:0]       stall_phase = '0;

	prufer_sequence_decode #(
		.MAX_VERTICES(MAX_VERTICES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_symbol(code_symbol),
		.is_last(is_last),
		.edge_valid(edge_valid),
		.edge_stall(edge_stall),
		.edge_low(edge_low),
		.edge_high(edge_high),
		.last_edge(last_edge),
		.bad_sequence(bad_sequence)
	);

	always #5 clk = ~clk;

	function automatic void push_edge(input int lo, input int hi, input bit last, input bit bad);
		tree_edge_t e;
		e.lo   = lo[SYM_W-1:0];
		e.hi   = hi[SYM_W-1:0];
		e.last = last;
		e.bad  = bad;
		expected_edges.push_back(e);
	endfunction

	// Takes one accepted symbol; on the last one of a run, rebuilds the tree edge by edge or predicts an error result.
	task automatic absorb_symbol(input logic [SYM_W-1:0] sym, input logic last);
		int                      occ [MAX_VERTICES];
		logic [MAX_VERTICES-1:0] taken;
		int                      len, pos, lbl, leaf, first_free;
		bit                      found;
		if (sym_count < MAX_VERTICES) code_mem[sym_count[SYM_W-1:0]] = sym;
		if (sym >= vcount) run_bad = 1'b1;
		if (sym_count < COUNT_SAT) sym_count = sym_count + 1'b1;
		if (last) begin
			len = int'(vcount) - 2;
			if (vcount < N_MIN || vcount > MAX_VERTICES || int'(sym_count) != len)
				run_bad = 1'b1;
			if (run_bad) begin
				push_edge(0, 0, 1'b1, 1'b1);
			end else begin
				// Count how often each label still occurs from the current position on.
				for (lbl = 0; lbl < MAX_VERTICES; lbl++) occ[lbl] = 0;
				for (pos = 0; pos < len; pos++) occ[code_mem[pos]]++;
				taken = '0;
				// Join the smallest free leaf to each code symbol in turn.
				for (pos = 0; pos < len; pos++) begin
					found = 1'b0;
					leaf = 0;
					for (lbl = 0; lbl < int'(vcount); lbl++) begin
						if (!found && !taken[lbl] && occ[lbl] == 0) begin
							found = 1'b1;
							leaf = lbl;
						end
					end
					if (found) begin
						if (int'(code_mem[pos]) < leaf) push_edge(code_mem[pos], leaf, 1'b0, 1'b0);
						else push_edge(leaf, code_mem[pos], 1'b0, 1'b0);
						taken[leaf] = 1'b1;
					end
					occ[code_mem[pos]]--;
				end
				// The two labels still free form the final edge.
				first_free = -1;
				found = 1'b0;
				for (lbl = 0; lbl < int'(vcount); lbl++) begin
					if (!taken[lbl] && !found) begin
						if (first_free < 0) begin
							first_free = lbl;
						end else begin
							push_edge(first_free, lbl, 1'b1, 1'b0);
							found = 1'b1;
						end
					end
				end
			end
			sym_count = '0;
			run_bad = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Each accepted result is checked against the oldest expected one.
	always @(posedge clk) begin : check_results
		tree_edge_t want;
		if (arst_n === 1'b1 && edge_valid === 1'b1 && edge_stall === 1'b0) begin
			if (expected_edges.size() == 0) begin
				report_mismatch("unexpected result, edge_low", edge_low, -1);
			end else begin
				want = expected_edges.pop_front();
				if (edge_low !== want.lo) report_mismatch("edge_low", edge_low, want.lo);
				if (edge_high !== want.hi) report_mismatch("edge_high", edge_high, want.hi);
				if (last_edge !== want.last) report_mismatch("last_edge", last_edge, want.last);
				if (bad_sequence !== want.bad)
					report_mismatch("bad_sequence", bad_sequence, want.bad);
			end
		end
	end

	// The receiver stalls according to the mode the current phase picked.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		case (stall_mode)
			STALL_NONE:  edge_stall <= 1'b0;
			STALL_LIGHT: edge_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: edge_stall <= ($urandom_range(0, 3) != 0);
			default:     edge_stall <= stall_phase[2] & stall_phase[0];
		endcase
	end

	// Ends the run when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((code_valid && !code_stall) || (edge_valid && !edge_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles at %0t", idle_cycles, $time);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one request, with bursts and, when enabled, random gaps, and predicts on acceptance.
	task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on) begin
				code_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		code_valid <= 1'b1;
		code_symbol <= sym;
		is_last <= last;
		do @(posedge clk); while (code_stall);
		sent_count++;
		absorb_symbol(sym, last);
	endtask

	// Sends the queued code as one run, marking its final symbol as last.
	task automatic send_code();
		int idx;
		for (idx = 0; idx < pending_code.size(); idx++)
			send_symbol(pending_code[idx], idx == pending_code.size() - 1);
		pending_code.delete();
	endtask

	task automatic wait_for_results();
		code_valid <= 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
	endtask

	// The vertex count changes only once the decoder has gone quiet.
	task automatic write_vertex_count(input logic [CFG_W-1:0] value);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vcount = value;
	endtask

	// Three vertices after reset: single-symbol codes, including out-of-range ones.
	task automatic test_reset_default();
		pending_code.push_back(5'd0);
		send_code();
		pending_code.push_back(5'd2);
		send_code();
		pending_code.push_back(5'd3);
		send_code();
		pending_code.push_back(5'd31);
		send_code();
	endtask

	// Small trees: star, path and a symbol at the top label.
	task automatic test_small_trees();
		write_vertex_count(6'd4);
		pending_code.push_back(5'd3);
		pending_code.push_back(5'd3);
		send_code();
		pending_code.push_back(5'd0);
		pending_code.push_back(5'd0);
		send_code();
		pending_code.push_back(5'd1);
		pending_code.push_back(5'd2);
		send_code();
		write_vertex_count(6'd5);
		pending_code.push_back(5'd4);
		pending_code.push_back(5'd0);
		pending_code.push_back(5'd4);
		send_code();
	endtask

	// Codes two symbols short and one symbol long are rejected.
	task automatic test_wrong_count();
		pending_code.push_back(5'd1);
		send_code();
		pending_code.push_back(5'd1);
		pending_code.push_back(5'd2);
		pending_code.push_back(5'd3);
		pending_code.push_back(5'd4);
		send_code();
	endtask

	// Vertex counts outside three to the maximum reject any code.
	task automatic test_bad_vertex_count();
		write_vertex_count(6'd0);
		pending_code.push_back(5'd0);
		send_code();
		write_vertex_count(6'd2);
		pending_code.push_back(5'd0);
		send_code();
		write_vertex_count(6'd33);
		pending_code.push_back(5'd16);
		send_code();
		write_vertex_count(6'd63);
		pending_code.push_back(5'd31);
		send_code();
	endtask

	// Random phases of vertex count, idling and run shape, mostly valid codes.
	task automatic test_random_runs();
		int               n, len, idx, stop_at, pick;
		run_kind_t        kind;
		bit               clustered;
		logic [SYM_W-1:0] hub_a, hub_b;
		stop_at = sent_count + RANDOM_ITEMS;
		// Largest tree first, with both extreme labels, then a count past saturation.
		write_vertex_count(6'd32);
		stall_mode = STALL_LIGHT;
		gaps_on = 1'b1;
		for (idx = 0; idx < 30; idx++) pending_code.push_back(SYM_W'($urandom_range(0, 31)));
		pending_code[3] = 5'd31;
		pending_code[17] = 5'd0;
		send_code();
		for (idx = 0; idx < 64 + 30; idx++)
			pending_code.push_back(SYM_W'($urandom_range(0, 31)));
		send_code();
		wait_for_results();
		while (sent_count < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick < 12) n = $urandom_range(3, 8);
			else if (pick < 16) n = $urandom_range(9, 31);
			else if (pick < 18) n = 32;
			else if (pick == 18) n = $urandom_range(0, 2);
			else n = $urandom_range(33, 63);
			write_vertex_count(n[CFG_W-1:0]);
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 4)) begin
				pick = $urandom_range(0, 9);
				if (n < 3 || n > MAX_VERTICES || pick == 9) kind = RUN_NOISE;
				else if (pick == 8) kind = RUN_BAD_COUNT;
				else if (pick == 7) kind = RUN_BAD_SYMBOL;
				else kind = RUN_GOOD;
				case (kind)
					RUN_GOOD, RUN_BAD_SYMBOL: begin
						// Some codes draw from two hub labels to build stars and paths.
						clustered = ($urandom_range(0, 2) == 0);
						hub_a = SYM_W'($urandom_range(0, n - 1));
						hub_b = SYM_W'($urandom_range(0, n - 1));
						for (idx = 0; idx < n - 2; idx++) begin
							if (clustered) pending_code.push_back($urandom_range(0, 1) ? hub_a : hub_b);
							else pending_code.push_back(SYM_W'($urandom_range(0, n - 1)));
						end
						if (kind == RUN_BAD_SYMBOL) begin
							if (n < MAX_VERTICES)
								pending_code[$urandom_range(0, n - 3)] =
									SYM_W'($urandom_range(n, 31));
							else
								pending_code.push_back(SYM_W'($urandom_range(0, 31)));
						end
					end
					RUN_BAD_COUNT: begin
						len = $urandom_range(1, n + 2);
						if (len == n - 2) len++;
						for (idx = 0; idx < len; idx++)
							pending_code.push_back(SYM_W'($urandom_range(0, n - 1)));
					end
					default: begin
						len = $urandom_range(1, 8);
						for (idx = 0; idx < len; idx++)
							pending_code.push_back(SYM_W'($urandom_range(0, 31)));
					end
				endcase
				// Now and then the sender holds off until the decoder has drained.
				if ($urandom_range(0, 15) == 0) wait_for_results();
				send_code();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_default();
		test_small_trees();
		test_wrong_count();
		test_bad_vertex_count();
		test_random_runs();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
